### sv/assert_macros.svh
// Assertion macros shared by the console writer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// The condition must never be true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

### sv/tcw_pkg.sv
// Types and constants shared by the text console writer modules.
`default_nettype none

package tcw_pkg;

  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] NIBBLE_MASK  = 8'h0F;

  localparam int         CFG_IDX_W  = 2;
  localparam int         CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 2'd1;

  localparam logic [3:0] FOREGROUND_RESET = 4'd7;
  localparam logic [3:0] BACKGROUND_RESET = 4'd0;

  localparam logic       ACTION_PUT  = 1'b0;
  localparam logic       ACTION_READ = 1'b1;

  typedef struct packed {
    logic        action;
    logic [7:0]  char_code;
    logic        end_of_buffer;
    logic [10:0] cell_index;
  } tcw_in_t;

  typedef struct packed {
    logic [7:0]  cell_char;
    logic [7:0]  cell_attribute;
    logic [10:0] cursor_position;
    logic        cursor_moved;
  } tcw_out_t;

  typedef struct packed {
    logic clear_step;
    logic put;
    logic rd_issue;
    logic rd_finish;
    logic scroll_step;
  } tcw_cmd_t;

  typedef struct packed {
    logic out_free;
    logic put_wraps;
    logic sweep_last;
  } tcw_sts_t;

endpackage

`default_nettype wire

### sv/tcw_ctrl.sv
// Controller state machine of the text console writer.
`default_nettype none
`include "assert_macros.svh"

module tcw_ctrl
  import tcw_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_action,
  output logic          in_ready,
  input  wire tcw_sts_t sts,
  output tcw_cmd_t      cmd
);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_READ   = 2'd2;
  localparam logic [1:0] ST_SCROLL = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       in_fire;

  assign in_ready = (state_r == ST_IDLE) && sts.out_free;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.sweep_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (in_action == ACTION_READ) begin
            cmd.rd_issue = 1'b1;
            state_nxt    = ST_READ;
          end else begin
            cmd.put = 1'b1;
            if (sts.put_wraps) state_nxt = ST_SCROLL;
          end
        end
      end
      ST_READ: begin
        cmd.rd_finish = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_SCROLL: begin
        cmd.scroll_step = 1'b1;
        if (sts.sweep_last) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ASSERT_CLK(a_read_follows, clk, rst_n, (in_fire && in_action == ACTION_READ) |=> (state_r == ST_READ), "read transfer did not enter the read state")
  `ASSERT_CLK(a_wrap_scrolls, clk, rst_n, (in_fire && in_action == ACTION_PUT && sts.put_wraps) |=> (state_r == ST_SCROLL), "full screen did not start a scroll")
  `ASSERT_CLK(a_scroll_ends, clk, rst_n, (state_r == ST_SCROLL && sts.sweep_last) |=> (state_r == ST_IDLE), "scroll sweep overran its last cell")

endmodule

`default_nettype wire

### sv/tcw_datapath.sv
// Datapath of the text console writer: screen store, positions, colours and result register.
`default_nettype none
`include "assert_macros.svh"

module tcw_datapath
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire tcw_in_t               in_data,
  input  wire tcw_cmd_t              cmd,
  output tcw_sts_t                   sts,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output tcw_out_t                   out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int P_W    = $clog2(CELLS + COLUMNS);
  localparam int COL_W  = $clog2(COLUMNS);

  localparam logic [P_W-1:0]    CELLS_P     = P_W'(CELLS);
  localparam logic [P_W-1:0]    COLS_P      = P_W'(COLUMNS);
  localparam logic [P_W-1:0]    LAST_ROW_P  = P_W'(CELLS - COLUMNS);
  localparam logic [P_W-1:0]    LAST_READ_P = P_W'(CELLS - COLUMNS - 1);
  localparam logic [ADDR_W-1:0] LAST_CELL_A = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] ROW_A       = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] ROW_NEXT_A  = ADDR_W'(COLUMNS + 1);
  localparam logic [COL_W-1:0]  COL_LAST    = COL_W'(COLUMNS - 1);
  localparam logic [31:0]       CELLS_W     = 32'(CELLS);

  logic [15:0] cells_mem [CELLS];
  logic [15:0] rd_data_r;

  logic [ADDR_W-1:0] sweep_r, sweep_nxt;
  logic [P_W-1:0]    wp_r, wp_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [P_W-1:0]    cursor_r, cursor_nxt;
  logic [3:0]        fg_r, fg_nxt;
  logic [3:0]        bg_r, bg_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              eob_r, eob_nxt;
  logic              moved_r, moved_nxt;
  logic              in_range_r, in_range_nxt;
  tcw_out_t          out_data_r, out_data_nxt;
  logic              out_load;

  logic [7:0]        attr;
  logic [P_W-1:0]    pos0, pos1, sweep_p;
  logic [COL_W-1:0]  col0, col1;
  logic              is_nl, put_wraps, sweep_last, scroll_done;
  logic [31:0]       idx_w, cur_w, cur_nxt_w;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_wa, mem_ra;
  logic [15:0]       mem_wd;

  assign attr       = {bg_r, fg_r};
  assign pos0       = (wp_r >= CELLS_P) ? '0 : wp_r;
  assign col0       = (wp_r >= CELLS_P) ? '0 : col_r;
  assign is_nl      = in_data.char_code == NEWLINE_CODE;
  assign pos1       = is_nl ? (pos0 + COLS_P - P_W'(col0)) : (pos0 + P_W'(1));
  assign col1       = (is_nl || col0 == COL_LAST) ? '0 : col0 + COL_W'(1);
  assign put_wraps  = pos1 >= CELLS_P;
  assign sweep_p    = P_W'(sweep_r);
  assign sweep_last = sweep_r == LAST_CELL_A;
  assign scroll_done = cmd.scroll_step && sweep_last;
  assign idx_w      = 32'(in_data.cell_index);
  assign cursor_nxt = (cmd.put && !is_nl) ? pos1 : cursor_r;
  assign cur_w      = 32'(cursor_r);
  assign cur_nxt_w  = 32'(cursor_nxt);

  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.put_wraps  = put_wraps;
  assign sts.sweep_last = sweep_last;

  // Store port selection. During a scroll the read runs one cell ahead of the
  // write, so the row below is fetched before the row above is overwritten.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = sweep_r;
    mem_wd = '0;
    mem_re = 1'b0;
    mem_ra = sweep_r + ROW_NEXT_A;
    if (cmd.clear_step) begin
      mem_we = 1'b1;
    end
    if (cmd.put) begin
      mem_we = !is_nl;
      mem_wa = pos0[ADDR_W-1:0];
      mem_wd = {attr, in_data.char_code};
      mem_re = put_wraps;
      mem_ra = ROW_A;
    end
    if (cmd.rd_issue) begin
      mem_re = idx_w < CELLS_W;
      mem_ra = idx_w[ADDR_W-1:0];
    end
    if (cmd.scroll_step) begin
      mem_we = 1'b1;
      mem_wd = (sweep_p < LAST_ROW_P) ? {attr, rd_data_r[7:0]} : {attr, 8'h00};
      mem_re = sweep_p < LAST_READ_P;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) cells_mem[mem_wa] <= mem_wd;
    if (mem_re) rd_data_r <= cells_mem[mem_ra];
  end

  always_comb begin
    sweep_nxt     = sweep_r;
    wp_nxt        = wp_r;
    col_nxt       = col_r;
    fg_nxt        = fg_r;
    bg_nxt        = bg_r;
    eob_nxt       = eob_r;
    moved_nxt     = moved_r;
    in_range_nxt  = in_range_r;
    out_load      = 1'b0;
    out_data_nxt  = out_data_r;

    if (cmd.clear_step || cmd.scroll_step) begin
      sweep_nxt = sweep_last ? '0 : sweep_r + ADDR_W'(1);
    end

    if (cmd.put) begin
      sweep_nxt = '0;
      eob_nxt   = in_data.end_of_buffer;
      moved_nxt = !is_nl;
      if (!put_wraps) begin
        wp_nxt   = in_data.end_of_buffer ? '0 : pos1;
        col_nxt  = in_data.end_of_buffer ? '0 : col1;
        out_load = 1'b1;
        out_data_nxt = '{cell_char: 8'h00, cell_attribute: 8'h00,
                         cursor_position: cur_nxt_w[10:0], cursor_moved: !is_nl};
      end
    end

    if (scroll_done) begin
      wp_nxt   = eob_r ? '0 : LAST_ROW_P;
      col_nxt  = '0;
      out_load = 1'b1;
      out_data_nxt = '{cell_char: 8'h00, cell_attribute: 8'h00,
                       cursor_position: cur_w[10:0], cursor_moved: moved_r};
    end

    if (cmd.rd_issue) begin
      in_range_nxt = idx_w < CELLS_W;
    end

    if (cmd.rd_finish) begin
      out_load = 1'b1;
      out_data_nxt = '{cell_char: in_range_r ? rd_data_r[7:0] : 8'h00,
                       cell_attribute: in_range_r ? rd_data_r[15:8] : 8'h00,
                       cursor_position: cur_w[10:0], cursor_moved: 1'b0};
    end

    if (cfg_we) begin
      case (cfg_index)
        REG_FOREGROUND: fg_nxt = cfg_data[3:0] & NIBBLE_MASK[3:0];
        REG_BACKGROUND: bg_nxt = cfg_data[3:0] & NIBBLE_MASK[3:0];
        default: begin
        end
      endcase
    end

    out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= '0;
      wp_r        <= '0;
      col_r       <= '0;
      cursor_r    <= '0;
      fg_r        <= FOREGROUND_RESET;
      bg_r        <= BACKGROUND_RESET;
      out_valid_r <= 1'b0;
    end else begin
      sweep_r     <= sweep_nxt;
      wp_r        <= wp_nxt;
      col_r       <= col_nxt;
      cursor_r    <= cursor_nxt;
      fg_r        <= fg_nxt;
      bg_r        <= bg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    eob_r      <= eob_nxt;
    moved_r    <= moved_nxt;
    in_range_r <= in_range_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_CLK(a_put_result, clk, rst_n, (cmd.put && !put_wraps) |=> out_valid_r, "put without scroll gave no result")

endmodule

`default_nettype wire

### sv/text_console_writer_top.sv
// Top level of the text console writer: controller, datapath and port wiring.
//
// Input items arrive on in_valid/in_ready with one packed in_data word; each
// item yields exactly one result on out_valid/out_ready. A transfer on either
// channel happens at a rising edge where valid and ready are both high.
// A put that does not fill the screen has its result visible in the cycle
// after it is taken, so puts stream at one per cycle while out_ready is high.
// A read goes through the registered read port of the screen store and then
// the output register, and no input is taken until it is done. A put that
// runs past the last cell starts a scroll: the store is swept once, one cell
// per cycle, while no input is taken; the result follows the sweep.
// After reset the store is cleared by one pass over every cell with in_ready
// low. Colour writes on the cfg_ channel are always taken and apply to puts
// taken after them; they belong where no item is in flight, as a write
// during a scroll recolours the rest of the sweep. When the receiver stalls,
// the result waits in the output register and the next item is taken only
// once that register is free or is being emptied.
`default_nettype none

module text_console_writer_top
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire tcw_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output tcw_out_t                   out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  tcw_cmd_t cmd;
  tcw_sts_t sts;

  assign cfg_ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

`default_nettype wire

### sim/tb_text_console_writer_top.sv
// Self-checking testbench for the text console writer: random puts, reads and colour changes.
`default_nettype none

module tb_text_console_writer_top;
  import tcw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS          = 80;
  localparam int ROW_COUNT     = 25;
  localparam int CELL_COUNT    = COLS * ROW_COUNT;
  localparam int RANDOM_ITEMS  = 900;
  localparam int PHASE_ITEMS   = 150;
  localparam int LONG_HOLD     = 400;
  localparam int CYCLE_LIMIT   = 16000000;

  // Tracks the screen store, write position, cursor and colours, and holds
  // the results that the block owes for every accepted item.
  class console_tracker;
    bit [15:0]   cells [CELL_COUNT];
    int unsigned wpos;
    int unsigned cursor;
    bit [3:0]    fg;
    bit [3:0]    bg;
    tcw_out_t    expected_cells [$];
    int          errors;

    function new();
      foreach (cells[k]) cells[k] = '0;
      wpos   = 0;
      cursor = 0;
      fg     = FOREGROUND_RESET;
      bg     = BACKGROUND_RESET;
      errors = 0;
    endfunction

    function void set_colour(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_FOREGROUND) fg = data[3:0];
      else if (idx == REG_BACKGROUND) bg = data[3:0];
    endfunction

    function void scroll_up(bit [7:0] attr);
      for (int k = 0; k < CELL_COUNT - COLS; k++) cells[k] = {attr, cells[k + COLS][7:0]};
      for (int k = CELL_COUNT - COLS; k < CELL_COUNT; k++) cells[k] = {attr, 8'h00};
      wpos = CELL_COUNT - COLS;
    endfunction

    function void note_item(tcw_in_t item);
      tcw_out_t res;
      bit [7:0] attr;
      res = '0;
      if (item.action == ACTION_READ) begin
        if (item.cell_index < CELL_COUNT) begin
          res.cell_char      = cells[item.cell_index][7:0];
          res.cell_attribute = cells[item.cell_index][15:8];
        end
      end else begin
        attr = {bg, fg};
        if (wpos >= CELL_COUNT) wpos = 0;
        if (item.char_code == NEWLINE_CODE) begin
          wpos = wpos + COLS - (wpos % COLS);
        end else begin
          cells[wpos] = {attr, item.char_code};
          wpos++;
          cursor = wpos;
          res.cursor_moved = 1'b1;
        end
        if (wpos >= CELL_COUNT) scroll_up(attr);
        if (item.end_of_buffer) wpos = 0;
      end
      res.cursor_position = cursor[10:0];
      expected_cells.push_back(res);
    endfunction

    function void report_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(tcw_out_t got);
      tcw_out_t want;
      if (expected_cells.size() == 0) begin
        $display("%0t: result with none expected, expected nothing actual %h", $time, got);
        errors++;
      end else begin
        want = expected_cells.pop_front();
        report_field("cell_char", 32'(want.cell_char), 32'(got.cell_char));
        report_field("cell_attribute", 32'(want.cell_attribute), 32'(got.cell_attribute));
        report_field("cursor_position", 32'(want.cursor_position),
                     32'(got.cursor_position));
        report_field("cursor_moved", 32'(want.cursor_moved), 32'(got.cursor_moved));
      end
    endfunction

    function int pending_count();
      return expected_cells.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  tcw_in_t               in_data;
  logic                  out_valid;
  logic                  out_ready;
  tcw_out_t              out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  console_tracker tracker;
  int             items_sent;
  int             burst_left;
  bit             offering;
  bit             hold_toggle;

  text_console_writer_top #(
    .COLUMNS(COLS),
    .ROWS   (ROW_COUNT)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_result(out_data);
  end

  // Receiver: switches between stall patterns; a flip of hold_toggle asks for
  // one long hold-off so that the block backs up into its input.
  initial begin : receiver
    int mode;
    int mode_left;
    int stall_left;
    int hold_left;
    bit seen_toggle;
    mode        = 0;
    mode_left   = 0;
    stall_left  = 0;
    hold_left   = 0;
    seen_toggle = 1'b0;
    out_ready   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_toggle != seen_toggle) begin
        seen_toggle = hold_toggle;
        hold_left   = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (mode_left % 4) != 0;
          default: begin
            if (stall_left > 0) begin
              stall_left--;
              out_ready <= 1'b0;
            end else begin
              out_ready <= 1'b1;
              if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 10);
            end
          end
        endcase
      end
    end
  end

  // All driving tasks start and end at a falling edge.
  task automatic idle(int cycles);
    if (cycles > 0) begin
      if (offering) begin
        in_valid <= 1'b0;
        offering = 1'b0;
      end
      repeat (cycles) @(negedge clk);
    end
  endtask

  task automatic send_item(tcw_in_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    offering = 1'b1;
    do @(posedge clk); while (!in_ready);
    tracker.note_item(item);
    items_sent++;
    @(negedge clk);
    // Bursts of random length separated by random gaps.
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if ($urandom_range(0, 3) == 0) idle($urandom_range(5, 20));
      else idle($urandom_range(1, 4));
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(0, 12);
    end
  endtask

  task automatic put_char(logic [7:0] ch, logic eob);
    tcw_in_t item;
    item.action        = ACTION_PUT;
    item.char_code     = ch;
    item.end_of_buffer = eob;
    item.cell_index    = 11'($urandom_range(0, 2047));
    send_item(item);
  endtask

  task automatic read_cell(int unsigned idx, logic eob);
    tcw_in_t item;
    item.action        = ACTION_READ;
    item.char_code     = 8'($urandom_range(0, 255));
    item.end_of_buffer = eob;
    item.cell_index    = idx[10:0];
    send_item(item);
  endtask

  task automatic wait_all_results();
    idle(1);
    while (tracker.pending_count() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_colour(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [7:0] text_char(int nl_pct);
    if ($urandom_range(0, 99) < nl_pct) return NEWLINE_CODE;
    return 8'($urandom_range(0, 255));
  endfunction

  // Reads lean towards recently written cells and the rows a scroll touches.
  function automatic int unsigned pick_cell_index();
    int unsigned r;
    int unsigned d;
    r = $urandom_range(0, 99);
    d = $urandom_range(1, 8);
    if (r < 40 && tracker.cursor >= d) return tracker.cursor - d;
    if (r < 60) return $urandom_range(CELL_COUNT - 2 * COLS, CELL_COUNT - 1);
    if (r < 88) return $urandom_range(0, CELL_COUNT - 1);
    return $urandom_range(CELL_COUNT, 2047);
  endfunction

  task automatic write_call(int len, bit with_eob, int nl_pct);
    for (int i = 0; i < len; i++) put_char(text_char(nl_pct), with_eob && (i == len - 1));
  endtask

  // Run the position down to the last row and fill it, so that the final
  // character leaves the cursor past the end and the screen scrolls.
  task automatic fill_screen_end();
    int unsigned left;
    while (tracker.wpos < CELL_COUNT - COLS) put_char(NEWLINE_CODE, 1'b0);
    left = CELL_COUNT - tracker.wpos;
    for (int unsigned i = 0; i < left; i++) put_char(8'($urandom_range(32, 126)), 1'b0);
    read_cell(CELL_COUNT - 1, 1'b0);
    read_cell(CELL_COUNT - COLS - 1, 1'b0);
    put_char(8'($urandom_range(32, 126)), 1'b1);
  endtask

  task automatic random_call();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      write_call($urandom_range(1, 12), $urandom_range(0, 4) != 0, 15);
    end else if (r < 55) begin
      n = $urandom_range(1, 6);
      repeat (n) read_cell(pick_cell_index(), 1'($urandom_range(0, 1)));
    end else if (r < 70) begin
      write_call($urandom_range(30, 90), 1'($urandom_range(0, 1)), 35);
    end else if (r < 73) begin
      fill_screen_end();
    end else if (r < 90) begin
      n = $urandom_range(2, 5);
      repeat (n) begin
        put_char(text_char(10), 1'b0);
        read_cell(pick_cell_index(), 1'b0);
      end
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        if ($urandom_range(0, 1) != 0) begin
          read_cell($urandom_range(0, 2047), 1'($urandom_range(0, 1)));
        end else begin
          put_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  initial begin : stimulus
    int          phase;
    int          phase_end;
    int          target;
    logic [3:0]  fg_pick;
    logic [3:0]  bg_pick;
    tracker     = new();
    items_sent  = 0;
    burst_left  = 0;
    offering    = 1'b0;
    hold_toggle = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: cleared store, out-of-range reads, extreme bytes,
    // newline, end marks on puts and reads, colour changes.
    read_cell(0, 1'b0);
    read_cell(CELL_COUNT - 1, 1'b0);
    read_cell(2047, 1'b0);
    read_cell(CELL_COUNT, 1'b1);
    put_char(8'h41, 1'b0);
    put_char(8'h00, 1'b0);
    put_char(8'hFF, 1'b0);
    put_char(NEWLINE_CODE, 1'b0);
    put_char(8'h7E, 1'b1);
    put_char(NEWLINE_CODE, 1'b1);
    read_cell(0, 1'b0);
    read_cell(1, 1'b0);
    read_cell(2, 1'b0);
    read_cell(COLS, 1'b0);
    wait_all_results();
    cfg_write(REG_FOREGROUND, 8'hF3);
    cfg_write(REG_BACKGROUND, 8'h5C);
    put_char(8'h20, 1'b0);
    read_cell(0, 1'b0);
    read_cell(1, 1'b1);
    wait_all_results();
    cfg_write(2'($urandom_range(2, 3)), 8'hFF);
    put_char(8'h55, 1'b1);
    read_cell(1, 1'b0);

    target = items_sent + RANDOM_ITEMS;
    for (phase = 0; items_sent < target; phase++) begin
      // The sender pauses here until every owed result has arrived.
      wait_all_results();
      case (phase)
        0: begin fg_pick = 4'h0; bg_pick = 4'h0; end
        1: begin fg_pick = 4'hF; bg_pick = 4'hF; end
        2: begin fg_pick = FOREGROUND_RESET; bg_pick = BACKGROUND_RESET; end
        default: begin
          fg_pick = 4'($urandom_range(0, 15));
          bg_pick = 4'($urandom_range(0, 15));
        end
      endcase
      cfg_write(REG_FOREGROUND, {4'($urandom_range(0, 15)), fg_pick});
      cfg_write(REG_BACKGROUND, {4'($urandom_range(0, 15)), bg_pick});
      if ($urandom_range(0, 2) == 0) begin
        cfg_write(2'($urandom_range(2, 3)), 8'($urandom_range(0, 255)));
      end
      if (phase == 0) fill_screen_end();
      if (phase == 2 || phase == 5) hold_toggle = ~hold_toggle;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end && items_sent < target) random_call();
    end

    idle(1);
    while (tracker.pending_count() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (tracker.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

### text_console_writer_top.f
+incdir+sv
sv/tcw_pkg.sv
sv/tcw_ctrl.sv
sv/tcw_datapath.sv
sv/text_console_writer_top.sv
sim/tb_text_console_writer_top.sv
